>>> hw/rtl/dlc_pkg.sv
// Shared types and constants for the daylight locus chromaticity pipeline.
// Used by dlc_poly, dlc_div, dlc_ycalc and the top level. No dependencies.
`timescale 1ns / 1ps

package dlc_pkg;

  // Fraction bits of x and y (valid range 12..24)
  localparam int FRAC_BITS = 16;

  // Result field width
  localparam int OUT_W = 16;
  localparam logic [OUT_W-1:0] OUT_LIM = (FRAC_BITS >= OUT_W) ? {OUT_W{1'b1}} :
                                         OUT_W'((64'd1 << FRAC_BITS) - 64'd1);

  // Temperature window, kelvin
  localparam int TIN_W = 16;
  localparam logic [TIN_W-1:0] T_MIN  = 16'd4000;
  localparam logic [TIN_W-1:0] T_KNEE = 16'd7000;
  localparam logic [TIN_W-1:0] T_MAX  = 16'd25000;

  // Datapath widths for an in-window temperature (T < 2^15)
  localparam int T_W      = 15;
  localparam int S1_W     = 33;
  localparam int T2_W     = 30;
  localparam int S2_W     = 48;
  localparam int T3_W     = 45;
  localparam int S2_SPLIT = 24;
  localparam int T3_SPLIT = 22;
  localparam int NUM_W    = 64;
  localparam int DEN_W    = 64;

  // Cubic coefficients, scaled: a0, a1*1e3, a2*1e6, a3*1e9 (units of 1e-6)
  localparam logic [17:0] A0_LO = 18'd244063;
  localparam logic [17:0] A0_HI = 18'd237040;
  localparam logic [27:0] A1_LO = 28'd99110000;
  localparam logic [27:0] A1_HI = 28'd247480000;
  localparam logic [41:0] A2_LO = 42'd2967800000000;
  localparam logic [41:0] A2_HI = 42'd1901800000000;
  localparam logic signed [NUM_W-1:0] A3_LO = -64'sd4607000000000000;
  localparam logic signed [NUM_W-1:0] A3_HI = -64'sd2006400000000000;
  localparam logic [19:0] DEN_SCALE = 20'd1000000;

  // y = (-600 x^2 + 574 x - 55) / 200, with rounding offset 100
  localparam int Y_LIN  = 574;
  localparam int Y_SQ   = 600;
  localparam int Y_OFS  = 55;
  localparam int Y_DIV  = 200;
  localparam int Y_HALF = 100;

  localparam int XSQ_W = 2 * OUT_W;
  localparam int XS_W  = OUT_W + 10;
  localparam int YV_A  = XS_W + FRAC_BITS;
  localparam int YV_B  = XSQ_W + 10;
  localparam int YV_C  = 2 * FRAC_BITS + 6;
  localparam int YV_AB = (YV_A > YV_B) ? YV_A : YV_B;
  localparam int YV_W  = ((YV_AB > YV_C) ? YV_AB : YV_C) + 1;
  // scaled y numerator stays below 83 * 2^F
  localparam int V_W   = FRAC_BITS + 7;
  localparam int Q0_W  = FRAC_BITS + 1;

  // reciprocal of 200, truncated; error below one for V_W <= 32
  localparam int RECIP_SH = 32;
  localparam int RECIP_W  = 25;
  localparam logic [RECIP_W-1:0] RECIP_200 = RECIP_W'((64'd1 << RECIP_SH) / 64'd200);

  // Stage counts
  localparam int POLY_LAT  = 4;
  localparam int DIV_LAT   = FRAC_BITS + 2;
  localparam int Y_LAT     = 5;
  localparam int TOTAL_LAT = POLY_LAT + DIV_LAT + Y_LAT;

  // Control that travels with each beat
  typedef struct packed {
    logic valid;
    logic in_range;
  } ctl_t;

endpackage

>>> hw/rtl/dlc_poly.sv
// Cubic numerator and denominator: num = Horner form in T, den = 1e6 * T^3.
// Four register stages. Depends on dlc_pkg.
`timescale 1ns / 1ps

module dlc_poly (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic [dlc_pkg::TIN_W-1:0]             temperature_k,
  output dlc_pkg::ctl_t                         ctl_out,
  output logic signed [dlc_pkg::NUM_W-1:0]      num,
  output logic [dlc_pkg::DEN_W-1:0]             den
);

  localparam int PH_W = dlc_pkg::S2_W - dlc_pkg::S2_SPLIT + dlc_pkg::T_W;
  localparam int PL_W = dlc_pkg::S2_SPLIT + dlc_pkg::T_W;
  localparam int DH_W = dlc_pkg::T3_W - dlc_pkg::T3_SPLIT + 20;
  localparam int DL_W = dlc_pkg::T3_SPLIT + 20;

  dlc_pkg::ctl_t ctl1, ctl2, ctl3, ctl_in;
  logic hi1, hi2, hi3, hi_in;
  logic [dlc_pkg::T_W-1:0]  t1, t2v, tv;
  logic [dlc_pkg::S1_W-1:0] s1, s1_next;
  logic [dlc_pkg::T2_W-1:0] tsq, tsq_next;
  logic [dlc_pkg::S2_W-1:0] s2, s2_next;
  logic [dlc_pkg::T3_W-1:0] tcu, tcu_next;
  logic [PH_W-1:0] ph, ph_next;
  logic [PL_W-1:0] pl, pl_next;
  logic [DH_W-1:0] dh, dh_next;
  logic [DL_W-1:0] dl, dl_next;
  logic [dlc_pkg::NUM_W-1:0] num_next;
  logic [dlc_pkg::DEN_W-1:0] den_next;

  // Range decode and first Horner step
  assign tv           = temperature_k[dlc_pkg::T_W-1:0];
  assign hi_in        = temperature_k > dlc_pkg::T_KNEE;
  assign ctl_in.valid = in_valid;
  assign ctl_in.in_range = (temperature_k >= dlc_pkg::T_MIN) &&
                           (temperature_k <= dlc_pkg::T_MAX);
  assign s1_next  = dlc_pkg::S1_W'(hi_in ? dlc_pkg::A0_HI : dlc_pkg::A0_LO) *
                    dlc_pkg::S1_W'(tv) +
                    dlc_pkg::S1_W'(hi_in ? dlc_pkg::A1_HI : dlc_pkg::A1_LO);
  assign tsq_next = dlc_pkg::T2_W'(tv) * dlc_pkg::T2_W'(tv);

  // Second Horner step and T^3
  assign s2_next  = dlc_pkg::S2_W'(s1) * dlc_pkg::S2_W'(t1) +
                    dlc_pkg::S2_W'(hi1 ? dlc_pkg::A2_HI : dlc_pkg::A2_LO);
  assign tcu_next = dlc_pkg::T3_W'(tsq) * dlc_pkg::T3_W'(t1);

  // Split products for the last Horner step and the denominator
  assign ph_next = PH_W'(s2[dlc_pkg::S2_W-1:dlc_pkg::S2_SPLIT]) * PH_W'(t2v);
  assign pl_next = PL_W'(s2[dlc_pkg::S2_SPLIT-1:0]) * PL_W'(t2v);
  assign dh_next = DH_W'(tcu[dlc_pkg::T3_W-1:dlc_pkg::T3_SPLIT]) * DH_W'(dlc_pkg::DEN_SCALE);
  assign dl_next = DL_W'(tcu[dlc_pkg::T3_SPLIT-1:0]) * DL_W'(dlc_pkg::DEN_SCALE);

  // Recombine partial products, add constant term
  assign num_next = dlc_pkg::NUM_W'({ph, {dlc_pkg::S2_SPLIT{1'b0}}}) +
                    dlc_pkg::NUM_W'(pl) +
                    dlc_pkg::NUM_W'(hi3 ? dlc_pkg::A3_HI : dlc_pkg::A3_LO);
  assign den_next = dlc_pkg::DEN_W'({dh, {dlc_pkg::T3_SPLIT{1'b0}}}) +
                    dlc_pkg::DEN_W'(dl);

  // Control stages
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1    <= '0;
      ctl2    <= '0;
      ctl3    <= '0;
      ctl_out <= '0;
    end else begin
      ctl1    <= ctl_in;
      ctl2    <= ctl1;
      ctl3    <= ctl2;
      ctl_out <= ctl3;
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    hi1 <= hi_in;
    t1  <= tv;
    s1  <= s1_next;
    tsq <= tsq_next;
    hi2 <= hi1;
    t2v <= t1;
    s2  <= s2_next;
    tcu <= tcu_next;
    hi3 <= hi2;
    ph  <= ph_next;
    pl  <= pl_next;
    dh  <= dh_next;
    dl  <= dl_next;
    num <= num_next;
    den <= den_next;
  end

endmodule

>>> hw/rtl/dlc_div.sv
// Pipelined restoring divider: x = round(num / den * 2^F), ties up, clamped.
// One quotient bit per stage, FRAC_BITS + 2 stages. Depends on dlc_pkg.
`timescale 1ns / 1ps

module dlc_div (
  input  logic                              clk,
  input  logic                              rst,
  input  dlc_pkg::ctl_t                     ctl_in,
  input  logic signed [dlc_pkg::NUM_W-1:0]  num,
  input  logic [dlc_pkg::DEN_W-1:0]         den,
  output dlc_pkg::ctl_t                     ctl_out,
  output logic [dlc_pkg::OUT_W-1:0]         x
);

  localparam int F     = dlc_pkg::FRAC_BITS;
  localparam int DW    = dlc_pkg::DEN_W;
  localparam int QR_W  = F + 1;
  localparam int CMP_W = (QR_W > dlc_pkg::OUT_W) ? QR_W : dlc_pkg::OUT_W;

  dlc_pkg::ctl_t   c   [0:F];
  logic [DW-1:0]   rem [0:F];
  logic [DW-1:0]   dv  [0:F];
  logic [F-1:0]    q   [0:F];
  logic            pos [0:F];
  logic            sat [0:F];

  // Entry: sign and integer-part checks
  always_ff @(posedge clk) begin
    if (rst) begin
      c[0] <= '0;
    end else begin
      c[0] <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    rem[0] <= $unsigned(num);
    dv[0]  <= den;
    q[0]   <= '0;
    pos[0] <= num > 0;
    sat[0] <= $unsigned(num) >= den;
  end

  // One quotient bit per stage
  for (genvar i = 0; i < F; i++) begin : g_bit
    logic [DW:0] two;
    logic [DW:0] diff;
    logic        ge;

    assign two  = {rem[i], 1'b0};
    assign diff = two - {1'b0, dv[i]};
    assign ge   = two >= {1'b0, dv[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        c[i+1] <= '0;
      end else begin
        c[i+1] <= c[i];
      end
    end

    always_ff @(posedge clk) begin
      rem[i+1] <= ge ? diff[DW-1:0] : two[DW-1:0];
      dv[i+1]  <= dv[i];
      q[i+1]   <= {q[i][F-2:0], ge};
      pos[i+1] <= pos[i];
      sat[i+1] <= sat[i];
    end
  end

  // Round half up, then clamp to the output format
  logic [DW:0]   two_f;
  logic          up;
  logic [QR_W-1:0] qr;
  logic [dlc_pkg::OUT_W-1:0] x_next;

  assign two_f = {rem[F], 1'b0};
  assign up    = two_f >= {1'b0, dv[F]};
  assign qr    = {1'b0, q[F]} + QR_W'(up);

  always_comb begin
    if (!pos[F]) begin
      x_next = '0;
    end else if (sat[F] || (CMP_W'(qr) > CMP_W'(dlc_pkg::OUT_LIM))) begin
      x_next = dlc_pkg::OUT_LIM;
    end else begin
      x_next = dlc_pkg::OUT_W'(qr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= c[F];
    end
  end

  always_ff @(posedge clk) begin
    x <= x_next;
  end

endmodule

>>> hw/rtl/dlc_ycalc.sv
// y from the rounded x: round((-600 x^2 + 574 x 2^F - 55 2^2F) / (200 2^F)).
// Five register stages, range gating at the output. Depends on dlc_pkg.
`timescale 1ns / 1ps

module dlc_ycalc (
  input  logic                       clk,
  input  logic                       rst,
  input  dlc_pkg::ctl_t              ctl_in,
  input  logic [dlc_pkg::OUT_W-1:0]  x,
  output logic                       done,
  output logic [dlc_pkg::OUT_W-1:0]  chroma_x,
  output logic [dlc_pkg::OUT_W-1:0]  chroma_y,
  output logic                       in_range
);

  localparam int F      = dlc_pkg::FRAC_BITS;
  localparam int OW     = dlc_pkg::OUT_W;
  localparam int YV_W   = dlc_pkg::YV_W;
  localparam int V_W    = dlc_pkg::V_W;
  localparam int Q0_W   = dlc_pkg::Q0_W;
  localparam int PROD_W = V_W + dlc_pkg::RECIP_W;
  localparam int CMP_W  = (Q0_W > OW) ? Q0_W : OW;

  dlc_pkg::ctl_t c1, c2, c3, c4;
  logic [OW-1:0] x1, x2, x3, x4;
  logic [dlc_pkg::XSQ_W-1:0] xsq1;
  logic [dlc_pkg::XS_W-1:0]  xs1;
  logic signed [YV_W-1:0]    yv2;
  logic [YV_W-1:0]           yv_next;
  logic                      pos3, pos4;
  logic [V_W-1:0]            v3, v4, v_next, r;
  logic [PROD_W-1:0]         prod;
  logic [Q0_W-1:0]           q4, qy;
  logic [OW-1:0]             y_next;

  // Scaled y numerator
  assign yv_next = (YV_W'(xs1) << F) -
                   YV_W'(xsq1) * YV_W'(dlc_pkg::Y_SQ) -
                   (YV_W'(dlc_pkg::Y_OFS) << (2 * F));

  // Drop the 2^F scale and add the rounding half
  assign v_next = V_W'(yv2 >>> F) + V_W'(dlc_pkg::Y_HALF);

  // Divide by 200: reciprocal estimate, one correction
  assign prod = PROD_W'(v3) * PROD_W'(dlc_pkg::RECIP_200);
  assign r    = v4 - V_W'(q4) * V_W'(dlc_pkg::Y_DIV);
  assign qy   = q4 + Q0_W'(r >= V_W'(dlc_pkg::Y_DIV));

  always_comb begin
    if (!pos4) begin
      y_next = '0;
    end else if (CMP_W'(qy) > CMP_W'(dlc_pkg::OUT_LIM)) begin
      y_next = dlc_pkg::OUT_LIM;
    end else begin
      y_next = OW'(qy);
    end
  end

  // Control stages
  always_ff @(posedge clk) begin
    if (rst) begin
      c1   <= '0;
      c2   <= '0;
      c3   <= '0;
      c4   <= '0;
      done <= 1'b0;
    end else begin
      c1   <= ctl_in;
      c2   <= c1;
      c3   <= c2;
      c4   <= c3;
      done <= c4.valid;
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    x1       <= x;
    xsq1     <= dlc_pkg::XSQ_W'(x) * dlc_pkg::XSQ_W'(x);
    xs1      <= dlc_pkg::XS_W'(x) * dlc_pkg::XS_W'(dlc_pkg::Y_LIN);
    x2       <= x1;
    yv2      <= yv_next;
    x3       <= x2;
    pos3     <= yv2 > 0;
    v3       <= v_next;
    x4       <= x3;
    pos4     <= pos3;
    v4       <= v3;
    q4       <= Q0_W'(prod >> dlc_pkg::RECIP_SH);
    in_range <= c4.in_range;
    chroma_x <= c4.in_range ? x4 : '0;
    chroma_y <= c4.in_range ? y_next : '0;
  end

endmodule

>>> hw/rtl/daylight_locus_chromaticity.sv
// Top level: CIE daylight locus (x, y) from colour temperature in kelvin.
// Instantiates dlc_poly, dlc_div and dlc_ycalc. Depends on dlc_pkg.
//
//   channel   ports                                  handshake
//   --------  -------------------------------------  ---------------------------
//   command   temperature_k                          start high, busy low
//   result    chroma_x, chroma_y, in_range           done, one-cycle strobe
//
// One temperature per cycle while busy is low; each result follows its
// command beat through dlc_poly, dlc_div and dlc_ycalc. The restoring
// divider, one quotient bit per stage, is the deepest of the three.
// busy is high only during reset; reset clears every valid bit in flight.
// The receiver cannot stall, so no stage ever holds.
`timescale 1ns / 1ps

module daylight_locus_chromaticity (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [dlc_pkg::TIN_W-1:0]  temperature_k,
  output logic                       done,
  output logic [dlc_pkg::OUT_W-1:0]  chroma_x,
  output logic [dlc_pkg::OUT_W-1:0]  chroma_y,
  output logic                       in_range
);

  logic                              accept;
  dlc_pkg::ctl_t                     poly_ctl, div_ctl;
  logic signed [dlc_pkg::NUM_W-1:0]  num;
  logic [dlc_pkg::DEN_W-1:0]         den;
  logic [dlc_pkg::OUT_W-1:0]         x_val;

  assign busy   = rst;
  assign accept = start && !busy;

  dlc_poly u_poly (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (accept),
    .temperature_k (temperature_k),
    .ctl_out       (poly_ctl),
    .num           (num),
    .den           (den)
  );

  dlc_div u_div (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (poly_ctl),
    .num     (num),
    .den     (den),
    .ctl_out (div_ctl),
    .x       (x_val)
  );

  dlc_ycalc u_ycalc (
    .clk      (clk),
    .rst      (rst),
    .ctl_in   (div_ctl),
    .x        (x_val),
    .done     (done),
    .chroma_x (chroma_x),
    .chroma_y (chroma_y),
    .in_range (in_range)
  );

  // Every command beat yields a result strobe
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(dlc_pkg::TOTAL_LAT) done)
    else $error("command beat without result strobe");

  // Every result strobe traces back to a command beat
  a_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, dlc_pkg::TOTAL_LAT))
    else $error("result strobe without command beat");

  // Range flag follows the temperature of its own beat
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> in_range == $past((temperature_k >= dlc_pkg::T_MIN) &&
                               (temperature_k <= dlc_pkg::T_MAX), dlc_pkg::TOTAL_LAT))
    else $error("in_range does not match temperature");

  // Out-of-window results are zero
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !in_range) |-> (chroma_x == '0) && (chroma_y == '0))
    else $error("nonzero chromaticity outside window");

  // Results stay within the fixed-point format
  a_limit: assert property (@(posedge clk) disable iff (rst)
    done |-> (chroma_x <= dlc_pkg::OUT_LIM) && (chroma_y <= dlc_pkg::OUT_LIM))
    else $error("chromaticity above format limit");

endmodule

>>> tb/tb_daylight_locus_chromaticity.sv
// Self-checking testbench for daylight_locus_chromaticity: directed table, then random
// temperatures; results checked against a typed row or an in-bench locus predictor.
// Depends on dlc_pkg and the daylight_locus_chromaticity RTL.
`timescale 1ns / 1ps

module tb_daylight_locus_chromaticity;

  localparam int F         = dlc_pkg::FRAC_BITS;
  localparam int N_RANDOM  = 640;
  localparam int N_STEADY  = 130;   // final random beats sent back to back
  localparam int DRAIN_CYC = dlc_pkg::TOTAL_LAT + 10;

  // Cubic coefficients in units of 1e-6: a3, a2, a1, a0
  localparam longint LO_A3 = -4607000;
  localparam longint LO_A2 = 2967800;
  localparam longint LO_A1 = 99110;
  localparam longint LO_A0 = 244063;
  localparam longint HI_A3 = -2006400;
  localparam longint HI_A2 = 1901800;
  localparam longint HI_A1 = 247480;
  localparam longint HI_A0 = 237040;

  // One locus point, tagged with the temperature that produced it
  typedef struct packed {
    logic [dlc_pkg::TIN_W-1:0] temp;
    logic [dlc_pkg::OUT_W-1:0] x;
    logic [dlc_pkg::OUT_W-1:0] y;
    logic                      rng;
  } locus_pt_t;

  // Directed row: when fixed is set, the typed point is the expectation
  typedef struct packed {
    logic [dlc_pkg::TIN_W-1:0] temp;
    logic                      fixed;
    logic [dlc_pkg::OUT_W-1:0] x;
    logic [dlc_pkg::OUT_W-1:0] y;
    logic                      rng;
  } dir_row_t;

  localparam int N_DIR = 20;
  dir_row_t dir_tab [N_DIR] = '{
    '{16'd0,     1'b1, 16'd0, 16'd0, 1'b0},
    '{16'd1,     1'b1, 16'd0, 16'd0, 1'b0},
    '{16'd3999,  1'b1, 16'd0, 16'd0, 1'b0},
    '{16'd4000,  1'b0, 16'd0, 16'd0, 1'b0},
    '{16'd4001,  1'b0, 16'd0, 16'd0, 1'b0},
    '{16'd5000,  1'b0, 16'd0, 16'd0, 1'b0},
    '{16'd6500,  1'b0, 16'd0, 16'd0, 1'b0},
    '{16'd6999,  1'b0, 16'd0, 16'd0, 1'b0},
    '{16'd7000,  1'b0, 16'd0, 16'd0, 1'b0},
    '{16'd7001,  1'b0, 16'd0, 16'd0, 1'b0},
    '{16'd10000, 1'b0, 16'd0, 16'd0, 1'b0},
    '{16'd16384, 1'b0, 16'd0, 16'd0, 1'b0},
    '{16'd20000, 1'b0, 16'd0, 16'd0, 1'b0},
    '{16'd24999, 1'b0, 16'd0, 16'd0, 1'b0},
    '{16'd25000, 1'b0, 16'd0, 16'd0, 1'b0},
    '{16'd25001, 1'b1, 16'd0, 16'd0, 1'b0},
    '{16'd32767, 1'b1, 16'd0, 16'd0, 1'b0},
    '{16'd32768, 1'b1, 16'd0, 16'd0, 1'b0},
    '{16'd65535, 1'b1, 16'd0, 16'd0, 1'b0},
    '{16'd4000,  1'b0, 16'd0, 16'd0, 1'b0}
  };

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic [dlc_pkg::TIN_W-1:0] temperature_k;
  logic                      done;
  logic [dlc_pkg::OUT_W-1:0] chroma_x;
  logic [dlc_pkg::OUT_W-1:0] chroma_y;
  logic                      in_range;

  locus_pt_t pending_pts [$];
  int        mismatches;
  int        pts_checked;
  int        pts_in_range;
  int        beats_sent;
  bit        gaps_on;

  daylight_locus_chromaticity u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .temperature_k (temperature_k),
    .done          (done),
    .chroma_x      (chroma_x),
    .chroma_y      (chroma_y),
    .in_range      (in_range)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Round-half-up Q0.F of the daylight cubic, then y from the rounded x
  function automatic locus_pt_t daylight_point(input logic [dlc_pkg::TIN_W-1:0] t_k);
    locus_pt_t               pt;
    logic signed [127:0]     tt, num, den, xf, yv, one, lim;
    longint                  a3, a2, a1, a0;
    pt.temp = t_k;
    pt.x    = '0;
    pt.y    = '0;
    pt.rng  = 1'b0;
    if (t_k < 16'd4000 || t_k > 16'd25000) begin
      return pt;
    end
    // 7000 K itself belongs to the lower set
    a3  = (t_k <= 16'd7000) ? LO_A3 : HI_A3;
    a2  = (t_k <= 16'd7000) ? LO_A2 : HI_A2;
    a1  = (t_k <= 16'd7000) ? LO_A1 : HI_A1;
    a0  = (t_k <= 16'd7000) ? LO_A0 : HI_A0;
    tt  = t_k;
    one = 128'sd1 <<< F;
    lim = one - 1;
    if (lim > 65535) lim = 65535;
    num = a3 * 1000000000 + a2 * 1000000 * tt + a1 * 1000 * tt * tt + a0 * tt * tt * tt;
    den = tt * tt * tt * 1000000;
    if (num <= 0) begin
      xf = 0;
    end else begin
      xf = ((num <<< (F + 1)) + den) / (2 * den);
      if (xf > lim) xf = lim;
    end
    yv = -600 * xf * xf + 574 * xf * one - 55 * one * one;
    if (yv > 0) begin
      yv = (yv + 100 * one) / (200 * one);
      if (yv > lim) yv = lim;
    end else begin
      yv = 0;
    end
    pt.x   = xf[dlc_pkg::OUT_W-1:0];
    pt.y   = yv[dlc_pkg::OUT_W-1:0];
    pt.rng = 1'b1;
    return pt;
  endfunction

  // Mostly in-window temperatures, weighted toward the range edges and the knee
  function automatic logic [dlc_pkg::TIN_W-1:0] pick_temp();
    case ($urandom_range(0, 9))
      0:       return 16'($urandom_range(0, 65535));
      1:       return 16'($urandom_range(3990, 4010));
      2:       return 16'($urandom_range(6990, 7010));
      3:       return 16'($urandom_range(24990, 25010));
      default: return 16'($urandom_range(4000, 25000));
    endcase
  endfunction

  // Drive one beat, with an optional leading gap; record its expectation
  task automatic send_temp(input logic [dlc_pkg::TIN_W-1:0] t_k, input bit fixed,
                           input locus_pt_t typed);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start         <= 1'b1;
    temperature_k <= t_k;
    do @(posedge clk); while (busy);
    pending_pts.push_back(fixed ? typed : daylight_point(t_k));
    beats_sent++;
  endtask

  // Hold start low until every outstanding result has come back
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin : result_check
    locus_pt_t want;
    if (!rst && done) begin
      if (pending_pts.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h in_range=%b",
                 $time, chroma_x, chroma_y, in_range);
        mismatches++;
      end else begin
        want = pending_pts.pop_front();
        pts_checked++;
        if (in_range) pts_in_range++;
        if (chroma_x !== want.x || chroma_y !== want.y || in_range !== want.rng) begin
          $display("%0t: T=%0d expected x=%h y=%h in_range=%b, got x=%h y=%h in_range=%b",
                   $time, want.temp, want.x, want.y, want.rng,
                   chroma_x, chroma_y, in_range);
          mismatches++;
        end
      end
    end
  end

  // Main sequence
  initial begin : stimulus
    locus_pt_t typed;
    mismatches    = 0;
    pts_checked   = 0;
    pts_in_range  = 0;
    beats_sent    = 0;
    gaps_on       = 1'b1;
    rst           = 1'b1;
    start         = 1'b0;
    temperature_k = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < N_DIR; i++) begin
      typed.temp = dir_tab[i].temp;
      typed.x    = dir_tab[i].x;
      typed.y    = dir_tab[i].y;
      typed.rng  = dir_tab[i].rng;
      send_temp(dir_tab[i].temp, dir_tab[i].fixed, typed);
    end
    drain_results();

    // random beats; full drain midway, no gaps in the tail
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) drain_results();
      if (i == N_RANDOM - N_STEADY) gaps_on = 1'b0;
      send_temp(pick_temp(), 1'b0, typed);
    end
    @(negedge clk);
    start <= 1'b0;

    while (pending_pts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Sent %0d temperatures (directed edges, knee and out-of-window values, random mix);",
             beats_sent);
    $display("checked %0d results, %0d inside the daylight window.", pts_checked, pts_in_range);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
